// File: src/ofdr_pkg.sv
// Odometry frame dead reckoning: shared types, constants and the CORDIC table.
// Has no dependencies. Every other file in src imports it.
package ofdr_pkg;

  localparam int FRAME_BYTES = 9;
  localparam int FILL_W      = 4;

  localparam logic [7:0] HDR0 = 8'hAA;
  localparam logic [7:0] HDR1 = 8'h55;
  localparam logic [7:0] TAIL = 8'hEE;

  // Configuration register indexes
  localparam logic [1:0] CFG_MAX_GAP = 2'd0;
  localparam logic [1:0] CFG_FLIP    = 2'd1;
  localparam logic [1:0] CFG_TYPE    = 2'd2;

  localparam int CORDIC_STEPS = 16;
  localparam int XW           = 34;
  localparam int ZW           = 24;
  localparam int HW           = 35;
  localparam int WRAP_TOP     = 9;

  localparam logic signed [XW-1:0] CORDIC_GAIN  = 34'sd652032874;
  localparam logic signed [ZW-1:0] HALF_PI_URAD = 24'sd1570796;
  localparam logic signed [ZW-1:0] PI_URAD      = 24'sd3141593;
  localparam logic signed [HW-1:0] TWO_PI_URAD  = 35'sd6283185;
  localparam logic signed [HW-1:0] WRAP_HI      = 35'sd3141592;

  // Classified frame handed from front to back
  typedef struct packed {
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic signed [15:0] wz;
    logic [15:0]        dt;
  } frame_t;

  typedef enum logic [3:0] {
    B_IDLE, B_CORDIC, B_FIN_CS, B_MUL_A, B_MUL_B, B_SUM,
    B_MUL_X, B_MUL_Y, B_MUL_H, B_ROUND, B_WRAP, B_DONE
  } back_state_t;

  // Arctangent of 2^-i in microradians
  function automatic logic [19:0] atan_urad(input logic [3:0] i);
    logic [19:0] v;
    case (i)
      4'd0:  v = 20'd785398;
      4'd1:  v = 20'd463648;
      4'd2:  v = 20'd244979;
      4'd3:  v = 20'd124355;
      4'd4:  v = 20'd62419;
      4'd5:  v = 20'd31240;
      4'd6:  v = 20'd15624;
      4'd7:  v = 20'd7812;
      4'd8:  v = 20'd3906;
      4'd9:  v = 20'd1953;
      4'd10: v = 20'd977;
      4'd11: v = 20'd488;
      4'd12: v = 20'd244;
      4'd13: v = 20'd122;
      4'd14: v = 20'd61;
      default: v = 20'd31;
    endcase
    return v;
  endfunction

endpackage

// File: src/ofdr_front.sv
// Front end: configuration registers, tick counter, byte window and frame check.
// Depends on ofdr_pkg. Pushes one frame_t per accepted frame.
module ofdr_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_mode,
  input  logic [7:0]          in_byte_value,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  output logic                push_valid,
  input  logic                push_ready,
  output ofdr_pkg::frame_t    push_data
);
  import ofdr_pkg::*;

  logic [15:0]       max_gap_r;
  logic              flip_r;
  logic [7:0]        type_r;
  logic [7:0]        win_r [FRAME_BYTES];
  logic [FILL_W-1:0] fill_r;
  logic              seen_r;
  logic [15:0]       elapsed_r;

  logic        take;
  logic        is_byte;
  logic        full;
  logic        match;
  logic signed [15:0] vy_raw;
  logic [15:0] dt_nxt;

  assign in_ready = push_ready;
  assign take     = in_valid && in_ready;
  assign is_byte  = take && !in_mode;
  assign full     = (fill_r == FILL_W'(FRAME_BYTES));
  assign match    = full && win_r[0] == HDR0 && win_r[1] == HDR1 &&
                    win_r[2] == type_r && in_byte_value == TAIL;

  // Decode the candidate and pick dt
  always_comb begin
    vy_raw = {win_r[6], win_r[5]};
    push_data.vx = {win_r[4], win_r[3]};
    push_data.wz = {win_r[8], win_r[7]};
    if (flip_r) begin
      push_data.vy = (vy_raw == 16'sh8000) ? 16'sh7FFF : -vy_raw;
    end else begin
      push_data.vy = vy_raw;
    end
    dt_nxt = seen_r ? elapsed_r : 16'd0;
    if (dt_nxt > max_gap_r) begin
      dt_nxt = 16'd0;
    end
    push_data.dt = dt_nxt;
  end

  assign push_valid = is_byte && match;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_gap_r <= 16'd200;
      flip_r    <= 1'b1;
      type_r    <= 8'h02;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_GAP: max_gap_r <= cfg_data;
        CFG_FLIP:    flip_r    <= cfg_data[0];
        CFG_TYPE:    type_r    <= cfg_data[7:0];
        default:     ;
      endcase
    end
  end

  // Window, fill count, tick counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r    <= '0;
      seen_r    <= 1'b0;
      elapsed_r <= '0;
      for (int i = 0; i < FRAME_BYTES; i++) begin
        win_r[i] <= 8'd0;
      end
    end else if (take) begin
      if (in_mode) begin
        if (elapsed_r != 16'hFFFF) begin
          elapsed_r <= elapsed_r + 16'd1;
        end
      end else if (!full) begin
        win_r[fill_r[FILL_W-1:0]] <= in_byte_value;
        fill_r <= fill_r + FILL_W'(1);
      end else if (match) begin
        fill_r    <= '0;
        seen_r    <= 1'b1;
        elapsed_r <= '0;
      end else begin
        // drop the oldest byte
        for (int i = 0; i < FRAME_BYTES - 1; i++) begin
          win_r[i] <= win_r[i+1];
        end
        win_r[FRAME_BYTES-1] <= in_byte_value;
      end
    end
  end

`ifndef SYNTH
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(FRAME_BYTES)) else $error("fill count out of range");
  a_frame_empties: assert property (@(posedge clk) disable iff (!rst_n)
    push_valid |=> (fill_r == '0 && elapsed_r == '0 && seen_r))
    else $error("accepted frame did not empty the window");
  a_push_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    push_valid |-> full && push_ready) else $error("push without full window");
`endif

endmodule

// File: src/ofdr_queue.sv
// Two-entry queue of classified frames between front and back.
// Depends on ofdr_pkg for frame_t.
module ofdr_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  ofdr_pkg::frame_t push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output ofdr_pkg::frame_t pop_data
);
  import ofdr_pkg::*;

  frame_t     mem_r [2];
  logic       wr_r;
  logic       rd_r;
  logic [1:0] cnt_r;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_data   = mem_r[rd_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_data;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wr_r <= ~wr_r;
      if (do_pop)  rd_r <= ~rd_r;
      cnt_r <= cnt_r + 2'(do_push) - 2'(do_pop);
    end
  end

`ifndef SYNTH
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("queue count overflow");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd1) |-> (wr_r != rd_r)) else $error("queue pointers disagree");
  a_ptr_same: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != 2'd1) |-> (wr_r == rd_r)) else $error("queue pointers disagree");
`endif

endmodule

// File: src/ofdr_back.sv
// Back end: CORDIC sine/cosine, rotation, position and heading integration.
// Depends on ofdr_pkg. Drives the registered result channel.
module ofdr_back #(
  parameter int POSITION_BITS = 48
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            pop_valid,
  output logic                            pop_ready,
  input  ofdr_pkg::frame_t                pop_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [POSITION_BITS-1:0] out_pos_x_um,
  output logic signed [POSITION_BITS-1:0] out_pos_y_um,
  output logic signed [22:0]              out_heading_urad,
  output logic signed [15:0]              out_speed_fwd_mm_s,
  output logic signed [15:0]              out_speed_side_mm_s,
  output logic signed [15:0]              out_turn_rate_mrad_s,
  output logic [15:0]                     out_dt_used_ticks
);
  import ofdr_pkg::*;

  localparam int PB = POSITION_BITS;
  localparam int SW = ((PB > 35) ? PB : 35) + 1;
  localparam logic signed [SW-1:0] POS_HI = (SW'(1) <<< (PB - 1)) - SW'(1);
  localparam logic signed [SW-1:0] POS_LO = -POS_HI - SW'(1);

  back_state_t state_r, state_nxt;
  logic        commit;

  frame_t                fr_r;
  logic signed [XW-1:0]  x_r, y_r;
  logic signed [ZW-1:0]  z_r;
  logic                  neg_r;
  logic [3:0]            it_r;
  logic signed [15:0]    c_r, s_r;
  logic signed [31:0]    pa_r, pb_r;
  logic signed [32:0]    ex_r, ey_r;
  logic signed [49:0]    dx_r, dy_r;
  logic signed [HW-1:0]  ht_r;
  logic [HW-1:0]         mag_r;
  logic                  hsign_r;
  logic [3:0]            k_r;
  logic signed [34:0]    rx_r, ry_r;
  logic signed [PB-1:0]  pos_x_r, pos_y_r;
  logic signed [22:0]    heading_r;
  logic                  out_valid_r;

  logic signed [ZW-1:0]  h_ext;
  logic signed [XW-1:0]  xf, yf;
  logic signed [16:0]    dt_s;
  logic [HW-1:0]         msub;
  logic signed [SW-1:0]  sum_x, sum_y, px_n, py_n;
  logic signed [HW-1:0]  hr, hw;

  // Q4.30 to Q1.15, round half up and saturate
  function automatic logic signed [15:0] q15(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] r;
    r = (v + XW'(16384)) >>> 15;
    if (r > XW'(32767)) return 16'sh7FFF;
    if (r < -XW'(32768)) return 16'sh8000;
    return r[15:0];
  endfunction

  assign h_ext = ZW'(heading_r);
  assign xf    = neg_r ? -x_r : x_r;
  assign yf    = neg_r ? -y_r : y_r;
  assign dt_s  = {1'b0, fr_r.dt};
  assign msub  = TWO_PI_URAD << k_r;

  // Saturating position update and heading wrap
  always_comb begin
    sum_x = SW'(pos_x_r) + SW'(rx_r);
    sum_y = SW'(pos_y_r) + SW'(ry_r);
    px_n  = (sum_x > POS_HI) ? POS_HI : ((sum_x < POS_LO) ? POS_LO : sum_x);
    py_n  = (sum_y > POS_HI) ? POS_HI : ((sum_y < POS_LO) ? POS_LO : sum_y);
    hr    = hsign_r ? -$signed(mag_r) : $signed(mag_r);
    if (hr > WRAP_HI) begin
      hw = hr - TWO_PI_URAD;
    end else if (hr < -WRAP_HI) begin
      hw = hr + TWO_PI_URAD;
    end else begin
      hw = hr;
    end
  end

  // Handshake outputs of the sequencer
  always_comb begin
    pop_ready = (state_r == B_IDLE);
    commit    = (state_r == B_DONE) && (!out_valid_r || out_ready);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE:   if (pop_valid) state_nxt = B_CORDIC;
      B_CORDIC: if (it_r == 4'(CORDIC_STEPS - 1)) state_nxt = B_FIN_CS;
      B_FIN_CS: state_nxt = B_MUL_A;
      B_MUL_A:  state_nxt = B_MUL_B;
      B_MUL_B:  state_nxt = B_SUM;
      B_SUM:    state_nxt = B_MUL_X;
      B_MUL_X:  state_nxt = B_MUL_Y;
      B_MUL_Y:  state_nxt = B_MUL_H;
      B_MUL_H:  state_nxt = B_ROUND;
      B_ROUND:  state_nxt = B_WRAP;
      B_WRAP:   if (k_r == 4'd0) state_nxt = B_DONE;
      B_DONE:   if (commit) state_nxt = B_IDLE;
      default:  state_nxt = B_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      heading_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (commit) begin
        out_valid_r <= 1'b1;
        pos_x_r     <= px_n[PB-1:0];
        pos_y_r     <= py_n[PB-1:0];
        heading_r   <= hw[22:0];
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state_r)
      B_IDLE: begin
        fr_r <= pop_data;
        x_r  <= CORDIC_GAIN;
        y_r  <= '0;
        it_r <= 4'd0;
        if (h_ext > HALF_PI_URAD) begin
          z_r <= h_ext - PI_URAD; neg_r <= 1'b1;
        end else if (h_ext < -HALF_PI_URAD) begin
          z_r <= h_ext + PI_URAD; neg_r <= 1'b1;
        end else begin
          z_r <= h_ext; neg_r <= 1'b0;
        end
      end
      B_CORDIC: begin
        it_r <= it_r + 4'd1;
        if (!z_r[ZW-1]) begin
          x_r <= x_r - (y_r >>> it_r);
          y_r <= y_r + (x_r >>> it_r);
          z_r <= z_r - ZW'(atan_urad(it_r));
        end else begin
          x_r <= x_r + (y_r >>> it_r);
          y_r <= y_r - (x_r >>> it_r);
          z_r <= z_r + ZW'(atan_urad(it_r));
        end
      end
      B_FIN_CS: begin
        c_r <= q15(xf);
        s_r <= q15(yf);
      end
      B_MUL_A: begin
        pa_r <= fr_r.vx * c_r;
        pb_r <= fr_r.vy * s_r;
      end
      B_MUL_B: begin
        ex_r <= 33'(pa_r) - 33'(pb_r);
        pa_r <= fr_r.vx * s_r;
        pb_r <= fr_r.vy * c_r;
      end
      B_SUM:   ey_r <= 33'(pa_r) + 33'(pb_r);
      B_MUL_X: dx_r <= 50'(ex_r) * 50'(dt_s);
      B_MUL_Y: dy_r <= 50'(ey_r) * 50'(dt_s);
      B_MUL_H: ht_r <= HW'(heading_r) + HW'(fr_r.wz) * HW'(dt_s);
      B_ROUND: begin
        rx_r    <= 35'((dx_r + 50'sd16384) >>> 15);
        ry_r    <= 35'((dy_r + 50'sd16384) >>> 15);
        hsign_r <= ht_r[HW-1];
        mag_r   <= ht_r[HW-1] ? HW'(-ht_r) : HW'(ht_r);
        k_r     <= 4'(WRAP_TOP);
      end
      B_WRAP: begin
        // one restoring step of the modulo per cycle
        if (mag_r >= msub) mag_r <= mag_r - msub;
        k_r <= k_r - 4'd1;
      end
      default: ;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (commit) begin
      out_pos_x_um         <= px_n[PB-1:0];
      out_pos_y_um         <= py_n[PB-1:0];
      out_heading_urad     <= hw[22:0];
      out_speed_fwd_mm_s   <= fr_r.vx;
      out_speed_side_mm_s  <= fr_r.vy;
      out_turn_rate_mrad_s <= fr_r.wz;
      out_dt_used_ticks    <= fr_r.dt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTH
  a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
    heading_r <= 23'sd3141592 && heading_r >= -23'sd3141592)
    else $error("heading left wrap range");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (pop_valid && pop_ready) |=> state_r == B_CORDIC)
    else $error("frame popped outside idle");
  a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> out_valid_r && state_r == B_IDLE)
    else $error("commit did not raise result");
`endif

endmodule

// File: src/odometry_frame_dead_reckoning_top.sv
// Top level of the odometry frame receiver with dead reckoning.
// Depends on ofdr_pkg, ofdr_front, ofdr_queue and ofdr_back.
//
// Bytes and 1 ms ticks enter on the in_ channel; a tick or a byte is taken
// when in_valid and in_ready are both high. A frame AA 55 <type> vx vy wz EE
// (int16 little-endian) produces one result. Each frame is worked through a
// sequencer in the back end: the frame is taken, 16 CORDIC iterations run,
// sine and cosine are rounded, seven multiply, sum and round steps follow,
// then ten modulo steps wrap the heading and the result is committed. The
// back end takes the next frame only when idle again, and a result that waits
// holds it in its commit state. A two-entry frame queue between front and
// back end lets bytes flow on while a frame is computed; in_ready drops only
// when that queue is full. Results sit in an output register until taken.
// Configuration: cfg_index 0 max gap ticks, 1 lateral flip, 2 frame type.
module odometry_frame_dead_reckoning_top #(
  parameter int POSITION_BITS = 48
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_mode,
  input  logic [7:0]                      in_byte_value,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_index,
  input  logic [15:0]                     cfg_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [POSITION_BITS-1:0] out_pos_x_um,
  output logic signed [POSITION_BITS-1:0] out_pos_y_um,
  output logic signed [22:0]              out_heading_urad,
  output logic signed [15:0]              out_speed_fwd_mm_s,
  output logic signed [15:0]              out_speed_side_mm_s,
  output logic signed [15:0]              out_turn_rate_mrad_s,
  output logic [15:0]                     out_dt_used_ticks
);
  import ofdr_pkg::*;

  logic   push_valid, push_ready, pop_valid, pop_ready;
  frame_t push_data, pop_data;

  ofdr_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_mode, .in_byte_value,
    .cfg_we, .cfg_index, .cfg_data,
    .push_valid, .push_ready, .push_data
  );

  ofdr_queue u_queue (
    .clk, .rst_n, .push_valid, .push_ready, .push_data,
    .pop_valid, .pop_ready, .pop_data
  );

  ofdr_back #(.POSITION_BITS(POSITION_BITS)) u_back (
    .clk, .rst_n, .pop_valid, .pop_ready, .pop_data,
    .out_valid, .out_ready, .out_pos_x_um, .out_pos_y_um, .out_heading_urad,
    .out_speed_fwd_mm_s, .out_speed_side_mm_s, .out_turn_rate_mrad_s,
    .out_dt_used_ticks
  );

endmodule
